[design/rpf_pkg.sv]
// ----------------------------------------------------------------------------
// rpf_pkg
// Types, codes and the crc-8 fold shared by the radio packet framer modules.
// ----------------------------------------------------------------------------
package rpf_pkg;

	localparam logic OP_START = 1'b0;
	localparam logic OP_BODY  = 1'b1;

	localparam logic [7:0] CRC_POLY  = 8'h8C;
	localparam logic [7:0] CRC_INIT  = 8'h00;
	localparam int         MAX_BYTES = 4;
	localparam int         CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int         IDX_W     = $clog2(MAX_BYTES);

	typedef struct packed {
		logic       operation;
		logic [7:0] sequence_number;
		logic [3:0] content_type;
		logic [7:0] body_length;
		logic [7:0] body_byte;
	} rpf_in_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_of_packet;
	} rpf_out_t;

	// bytes produced by one transaction, sent in index order
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      last;
	} rpf_burst_t;

	// reflected crc-8, one byte folded in eight shift steps
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[design/rpf_core.sv]
// ----------------------------------------------------------------------------
// rpf_core
// Input register, packet state and crc, builds the byte burst of each item.
// ----------------------------------------------------------------------------
module rpf_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rpf_pkg::rpf_in_t   in_data,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               can_load,
	output logic               load,
	output rpf_pkg::rpf_burst_t burst
);

	logic             valid_s1;
	rpf_pkg::rpf_in_t item_s1;
	logic [7:0]       device_id_q;
	logic             packet_open_q;
	logic [3:0]       rem_q;
	logic [7:0]       crc_q;

	logic             open_d;
	logic [3:0]       rem_d;
	logic [7:0]       crc_d;
	logic [3:0]       len;
	logic [3:0]       rem_dec;
	logic [7:0]       crc_fold;

	assign in_stall = valid_s1 && !can_load;
	assign load     = valid_s1 && can_load;

	assign len      = item_s1.body_length[3:0];
	assign rem_dec  = rem_q - 4'd1;
	assign crc_fold = rpf_pkg::crc8_fold(crc_q, item_s1.body_byte);

	always_comb begin
		burst   = '0;
		open_d  = packet_open_q;
		rem_d   = rem_q;
		crc_d   = crc_q;
		case (item_s1.operation)
			rpf_pkg::OP_START: begin
				burst.bytes[0] = device_id_q;
				burst.bytes[1] = item_s1.sequence_number;
				burst.bytes[2] = {item_s1.content_type, len};
				burst.bytes[3] = rpf_pkg::CRC_INIT;
				crc_d          = rpf_pkg::CRC_INIT;
				rem_d          = len;
				if (len == 4'd0) begin
					burst.count = rpf_pkg::CNT_W'(4);
					burst.last  = 1'b1;
					open_d      = 1'b0;
				end else begin
					burst.count = rpf_pkg::CNT_W'(3);
					open_d      = 1'b1;
				end
			end
			rpf_pkg::OP_BODY: begin
				// body bytes outside a packet give an empty burst
				if (packet_open_q) begin
					burst.bytes[0] = item_s1.body_byte;
					burst.bytes[1] = crc_fold;
					crc_d          = crc_fold;
					rem_d          = rem_dec;
					if (rem_dec == 4'd0) begin
						burst.count = rpf_pkg::CNT_W'(2);
						burst.last  = 1'b1;
						open_d      = 1'b0;
					end else begin
						burst.count = rpf_pkg::CNT_W'(1);
					end
				end
			end
			default: begin
				burst = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			device_id_q   <= 8'd0;
			packet_open_q <= 1'b0;
			rem_q         <= 4'd0;
			crc_q         <= rpf_pkg::CRC_INIT;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_we) begin
				device_id_q <= cfg_wdata;
			end
			if (load) begin
				packet_open_q <= open_d;
				rem_q         <= rem_d;
				crc_q         <= crc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

`ifndef SYNTHESIS
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		packet_open_q |-> rem_q != 4'd0)
		else $error("open packet with no body bytes left");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !can_load |=> valid_s1 && $stable(item_s1))
		else $error("held item lost or changed");
`endif

endmodule

[design/rpf_serial.sv]
// ----------------------------------------------------------------------------
// rpf_serial
// Result register that holds one burst and sends it a byte per transaction.
// ----------------------------------------------------------------------------
module rpf_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  rpf_pkg::rpf_burst_t burst,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_stall,
	output rpf_pkg::rpf_out_t   out_data
);

	logic [rpf_pkg::MAX_BYTES-1:0][7:0] bytes_q;
	logic [rpf_pkg::CNT_W-1:0]          cnt_q;
	logic [rpf_pkg::IDX_W-1:0]          idx_q;
	logic                               last_q;

	logic busy;
	logic final_byte;
	logic take;

	assign busy       = cnt_q != '0;
	assign final_byte = rpf_pkg::CNT_W'(idx_q) == cnt_q - rpf_pkg::CNT_W'(1);
	assign take       = busy && !out_stall;
	assign can_load   = !busy || (take && final_byte);

	assign out_valid               = busy;
	assign out_data.packet_byte    = bytes_q[idx_q];
	assign out_data.last_of_packet = last_q && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q  <= burst.count;
				idx_q  <= '0;
				last_q <= burst.last;
			end else if (take) begin
				if (final_byte) begin
					cnt_q <= '0;
				end else begin
					idx_q <= idx_q + rpf_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rpf_pkg::CNT_W'(idx_q) < cnt_q && cnt_q <= rpf_pkg::CNT_W'(rpf_pkg::MAX_BYTES))
		else $error("byte index outside held burst");

	a_closing_burst: assert property (@(posedge clk) disable iff (!arst_n)
		busy && last_q |-> cnt_q == rpf_pkg::CNT_W'(2) || cnt_q == rpf_pkg::CNT_W'(4))
		else $error("closing burst of unexpected length");
`endif

endmodule

[design/radio_packet_framer_crc8_unit.sv]
// ----------------------------------------------------------------------------
// radio_packet_framer_crc8_unit
// Frames radio packets: header bytes, body pass-through and closing crc-8.
// ----------------------------------------------------------------------------
// path: an accepted item enters the input register, then the result register
//   once that is free; throughput: one item per cycle while each gives at most
//   one byte and out_stall is low; an item with n bytes holds the single-byte
//   output until all n go (start: 3 or 4, final body byte: 2), bounding the rate
// reset: arst_n clears device id, packet state, crc and both valid flags
module radio_packet_framer_crc8_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rpf_pkg::rpf_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rpf_pkg::rpf_out_t out_data,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);

	logic                can_load;
	logic                load;
	rpf_pkg::rpf_burst_t burst;

	rpf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.can_load  (can_load),
		.load      (load),
		.burst     (burst)
	);

	rpf_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.burst     (burst),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for radio_packet_framer_crc8_unit. A queue-fed driver
// sends start and body transactions with random gaps, a monitor stalls the
// byte stream at random and checks every byte against an in-bench framer
// model, and the device id is rewritten between phases while the unit idles.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 10;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	rpf_pkg::rpf_in_t  in_data   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	rpf_pkg::rpf_out_t out_data;
	logic              cfg_we    = 1'b0;
	logic [7:0]        cfg_wdata = 8'h00;

	// framer model state
	logic [7:0] model_dev_id = 8'h00;
	logic       model_open   = 1'b0;
	logic [3:0] model_left   = 4'd0;
	logic [7:0] model_crc    = 8'h00;

	rpf_pkg::rpf_in_t  items_to_send[$];
	rpf_pkg::rpf_out_t frame_bytes_due[$];
	rpf_pkg::rpf_out_t due_byte;

	int  error_count = 0;
	int  idle_cycles = 0;
	int  gap_left    = 0;
	int  stall_left  = 0;
	logic idle_on    = 1'b1;

	radio_packet_framer_crc8_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(string msg);
		$display("%0t mismatch: %s", $time, msg);
		error_count++;
	endtask

	// bit-serial dallas crc, lsb of the data first
	function automatic logic [7:0] dallas_crc_step(logic [7:0] crc, logic [7:0] data);
		logic [7:0] acc;
		logic       mix;
		acc = crc;
		for (int b = 0; b < 8; b++) begin
			mix = acc[0] ^ data[b];
			acc = {1'b0, acc[7:1]};
			if (mix)
				acc = acc ^ rpf_pkg::CRC_POLY;
		end
		return acc;
	endfunction

	task automatic push_byte(logic [7:0] value, logic last);
		rpf_pkg::rpf_out_t r;
		r.packet_byte    = value;
		r.last_of_packet = last;
		frame_bytes_due.push_back(r);
	endtask

	task automatic frame_item(rpf_pkg::rpf_in_t it);
		logic [3:0] len;
		len = it.body_length[3:0];
		if (it.operation == rpf_pkg::OP_START) begin
			// a start abandons any packet in progress and reopens one unless its length is zero
			push_byte(model_dev_id, 1'b0);
			push_byte(it.sequence_number, 1'b0);
			push_byte({it.content_type, len}, 1'b0);
			model_crc  = rpf_pkg::CRC_INIT;
			model_left = len;
			model_open = (len != 4'd0);
			if (len == 4'd0)
				push_byte(model_crc, 1'b1);
		end else if (model_open) begin
			push_byte(it.body_byte, 1'b0);
			model_crc  = dallas_crc_step(model_crc, it.body_byte);
			model_left = model_left - 4'd1;
			if (model_left == 4'd0) begin
				push_byte(model_crc, 1'b1);
				model_open = 1'b0;
			end
		end
	endtask

	// mostly no idling, some short gaps, a few long ones
	function automatic int pick_idle();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic rpf_pkg::rpf_in_t rand_item(logic op);
		rpf_pkg::rpf_in_t it;
		it.operation       = op;
		it.sequence_number = 8'($urandom_range(0, 255));
		it.content_type    = 4'($urandom_range(0, 15));
		it.body_length     = 8'($urandom_range(0, 255));
		it.body_byte       = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic queue_item(logic op, logic [7:0] seq, logic [3:0] ctype,
			logic [7:0] len, logic [7:0] data);
		rpf_pkg::rpf_in_t it;
		it.operation       = op;
		it.sequence_number = seq;
		it.content_type    = ctype;
		it.body_length     = len;
		it.body_byte       = data;
		items_to_send.push_back(it);
	endtask

	task automatic random_phase(int n_items);
		rpf_pkg::rpf_in_t it;
		int               made;
		int               pick;
		int               len;
		int               cut;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// stray bytes, dropped unless a packet is still open
				items_to_send.push_back(rand_item(rpf_pkg::OP_BODY));
			end else begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = 15;
					default: len = $urandom_range(1, 15);
				endcase
				cut = len;
				// broken packet: cut short, the next start abandons it
				if (pick >= 88 && len > 1)
					cut = $urandom_range(0, len - 1);
				it = rand_item(rpf_pkg::OP_START);
				it.body_length[3:0] = 4'(len);
				items_to_send.push_back(it);
				made++;
				repeat (cut) begin
					items_to_send.push_back(rand_item(rpf_pkg::OP_BODY));
					made++;
				end
			end
		end
	endtask

	// wait until the unit has nothing left in flight
	task automatic settle();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || frame_bytes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_dev_id(logic [7:0] value);
		@(posedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= value;
		model_dev_id  = value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		cfg_wdata    <= 8'($urandom_range(0, 255));
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				frame_item(in_data);
			// a stalled transaction stays on the bus unchanged
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (items_to_send.size() > 0) begin
					in_valid <= 1'b1;
					in_data  <= items_to_send.pop_front();
					gap_left  = pick_idle();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frame_bytes_due.size() == 0) begin
					report_error($sformatf("unexpected byte %02h last %0b",
						out_data.packet_byte, out_data.last_of_packet));
				end else begin
					due_byte = frame_bytes_due.pop_front();
					if (out_data.packet_byte !== due_byte.packet_byte)
						report_error($sformatf("packet_byte %02h, expected %02h",
							out_data.packet_byte, due_byte.packet_byte));
					if (out_data.last_of_packet !== due_byte.last_of_packet)
						report_error($sformatf("last_of_packet %0b, expected %0b on byte %02h",
							out_data.last_of_packet, due_byte.last_of_packet,
							due_byte.packet_byte));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_idle();
				out_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, device id still at its reset value
		queue_item(rpf_pkg::OP_BODY, 8'hC3, 4'h9, 8'h21, 8'h5A);  // no packet open
		queue_item(rpf_pkg::OP_START, 8'h00, 4'h0, 8'h00, 8'h00); // empty body
		queue_item(rpf_pkg::OP_START, 8'hFF, 4'hF, 8'hF0, 8'hFF); // long length, nibble zero
		queue_item(rpf_pkg::OP_START, 8'h5C, 4'hA, 8'hF3, 8'h3C);
		queue_item(rpf_pkg::OP_BODY, 8'h00, 4'h0, 8'h00, 8'h00);
		queue_item(rpf_pkg::OP_BODY, 8'hFF, 4'hF, 8'hFF, 8'hFF);
		queue_item(rpf_pkg::OP_BODY, 8'h11, 4'h5, 8'h07, 8'h80);
		queue_item(rpf_pkg::OP_BODY, 8'h00, 4'h0, 8'h00, 8'h77);  // after the crc byte
		queue_item(rpf_pkg::OP_START, 8'h01, 4'h3, 8'h0F, 8'h00);
		queue_item(rpf_pkg::OP_BODY, 8'hAA, 4'h6, 8'h55, 8'h12);
		queue_item(rpf_pkg::OP_BODY, 8'h55, 4'h9, 8'hAA, 8'h34);
		queue_item(rpf_pkg::OP_START, 8'h02, 4'h0, 8'h01, 8'hFF); // restart mid-packet
		queue_item(rpf_pkg::OP_BODY, 8'h00, 4'h0, 8'h00, 8'hA5);
		queue_item(rpf_pkg::OP_START, 8'h80, 4'h8, 8'h82, 8'hFF);
		queue_item(rpf_pkg::OP_BODY, 8'hFF, 4'hF, 8'hFF, 8'h01);
		queue_item(rpf_pkg::OP_BODY, 8'h7F, 4'h7, 8'h70, 8'h00);
		queue_item(rpf_pkg::OP_START, 8'h7E, 4'h1, 8'h01, 8'h00);
		queue_item(rpf_pkg::OP_BODY, 8'h00, 4'h0, 8'h00, 8'hFF);
		settle();

		write_dev_id(8'hFF);
		random_phase(110);
		settle();

		write_dev_id(8'h00);
		random_phase(110);
		settle();

		// stretch with no gaps and no stalls
		idle_on = 1'b0;
		write_dev_id(8'($urandom_range(1, 254)));
		random_phase(110);
		settle();
		idle_on = 1'b1;

		write_dev_id(8'hA5);
		random_phase(120);
		settle();

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
